// ===== src/ssb_pkg.sv =====
// Shared types, constants and helpers of the shifted sprite blitter.
package ssb_pkg;

  // Screen height in scanlines; rows at or beyond this are off screen.
  localparam int SCREEN_ROWS = 192;

  // Width of the unwrapped address sum: base + byte column + sprite column.
  localparam int SUM_W = 14;

  // Configuration register indexes.
  localparam logic [2:0] REG_POS_X       = 3'd0;
  localparam logic [2:0] REG_POS_Y       = 3'd1;
  localparam logic [2:0] REG_WIDTH       = 3'd2;
  localparam logic [2:0] REG_HEIGHT      = 3'd3;
  localparam logic [2:0] REG_OPERATION   = 3'd4;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_XOR   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_KEEP  = 2'd3
  } blit_op_t;

  // One frame store write as issued by the sequencer.
  typedef struct packed {
    logic [SUM_W-1:0] addr;
    logic [7:0]       value;
    logic             oor;
    logic             last;
    logic             done;
    blit_op_t         mode;
  } wr_op_t;

  // One finished result beat.
  typedef struct packed {
    logic [12:0] addr;
    logic [7:0]  value;
    logic        oor;
    logic        last;
    logic        done;
    logic [7:0]  overlap;
  } wr_result_t;

  // Status of the read-modify-write stage seen by the sequencer.
  typedef struct packed {
    logic clear_busy;
    logic stage_busy;
  } rmw_status_t;

  // Interleaved scanline base offset of screen row y.
  function automatic logic [12:0] row_base(input logic [7:0] y);
    return {y[7:6], y[2:0], y[5:3], 5'b00000};
  endfunction

endpackage

// ===== src/ssb_rmw.sv =====
// Frame store memory with its clearing pass and the read-modify-write stage.
module ssb_rmw #(
  parameter int FRAME_BYTES = 6144
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                op_valid,
  input  ssb_pkg::wr_op_t     op,
  input  logic                restart,
  output ssb_pkg::rmw_status_t status,
  output logic                res_valid,
  output ssb_pkg::wr_result_t res
);
  import ssb_pkg::*;

  localparam int ADDR_W = $clog2(FRAME_BYTES);

  logic [7:0]        store [FRAME_BYTES];
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  logic              s1_valid;
  wr_op_t            s1_op;
  logic [7:0]        rd_data;

  logic              prev_valid;
  logic [SUM_W-1:0]  prev_addr;
  logic [7:0]        prev_data;

  logic [7:0]        accum;
  logic [7:0]        old_byte;
  logic [7:0]        new_byte;
  logic [7:0]        overlap_next;
  logic              wr_en;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [7:0]        mem_wd;

  // Old byte: zero when off the store, else the freshest copy of the entry.
  always_comb begin
    if (s1_op.oor) begin
      old_byte = 8'h00;
    end else if (prev_valid && (prev_addr == s1_op.addr)) begin
      old_byte = prev_data;
    end else begin
      old_byte = rd_data;
    end
  end

  always_comb begin
    unique case (s1_op.mode)
      OP_DRAW:  new_byte = s1_op.value;
      OP_XOR:   new_byte = old_byte ^ s1_op.value;
      OP_CLEAR: new_byte = old_byte & ~s1_op.value;
      default:  new_byte = old_byte;
    endcase
  end

  assign wr_en        = s1_valid && !s1_op.oor;
  assign overlap_next = (wr_en && (s1_op.mode == OP_XOR)) ? (accum | new_byte) : accum;

  assign mem_we = clearing || wr_en;
  assign mem_wa = clearing ? clr_addr : s1_op.addr[ADDR_W-1:0];
  assign mem_wd = clearing ? 8'h00 : new_byte;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
    if (op_valid && !op.oor) begin
      rd_data <= store[op.addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clr_addr   <= '0;
      s1_valid   <= 1'b0;
      prev_valid <= 1'b0;
      accum      <= 8'h00;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == ADDR_W'(FRAME_BYTES - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_valid   <= op_valid;
      prev_valid <= wr_en;
      if (restart) begin
        accum <= 8'h00;
      end else if (s1_valid) begin
        accum <= s1_op.done ? 8'h00 : overlap_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      s1_op <= op;
    end
    if (wr_en) begin
      prev_addr <= s1_op.addr;
      prev_data <= new_byte;
    end
  end

  assign res_valid     = s1_valid;
  assign res.addr      = s1_op.addr[12:0];
  assign res.value     = new_byte;
  assign res.oor       = s1_op.oor;
  assign res.last      = s1_op.last;
  assign res.done      = s1_op.done;
  assign res.overlap   = overlap_next;

  assign status.clear_busy = clearing;
  assign status.stage_busy = s1_valid;

  // No write may be issued while the clearing pass owns the store.
  a_no_issue_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !op_valid)
    else $error("write issued during clearing pass");

  // A dropped write never changes the overlap report.
  a_oor_keeps_overlap: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.oor) |-> (res.overlap == accum))
    else $error("out-of-range write changed overlap");

  // The final write of a sprite is always the last beat of its input byte.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op.done) |-> s1_op.last)
    else $error("sprite end without end of run");

  // The accumulator restarts after the final write of a sprite.
  a_done_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op.done) |=> (accum == 8'h00))
    else $error("overlap not cleared after sprite end");

endmodule

// ===== src/shifted_sprite_blitter_core.sv =====
// Top level of the shifted sprite blitter: sequencer, frame store stage and result queue.
//
// Usage. Program the position, size and operation through the cfg channel while the
// block is idle; every register write restarts the sprite. Then stream the sprite bytes,
// row major, one per beat on the s_ channel. Each byte produces one result beat on the
// m_ channel; the last byte of a sprite row produces a second beat that writes the bits
// shifted out past the right edge. m_tlast marks the final beat caused by one input byte,
// m_tuser flags dropped (out of range) writes and the final write of the sprite.
//
// Throughput is one input byte per cycle inside a row, while the queue has room and no clear
// is running; the last byte of a row costs an extra issue slot, because each write takes one
// issue slot on the single frame store read port and the row tail needs a slot of its own.
// An accepted byte reaches its first result beat through the synchronous store read and
// then the modify and write. A write that reads the entry written in the previous cycle
// takes the byte forwarded from that write.
//
// After reset the frame store is swept to zero, one byte per cycle, over all FRAME_BYTES
// entries (6144 by default); s_tready stays low during the sweep while cfg writes are
// taken as usual. Results go through a four-beat queue; when m_tready is held low the
// block keeps accepting bytes until the queue and the in-flight write would fill it.
module shifted_sprite_blitter_core #(
  parameter int FRAME_BYTES = 6144
) (
  input  logic        clk,
  input  logic        rst,
  // Sprite byte stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sprite_byte
  // Frame store write results.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [12:0] write_address, [20:13] write_value,
                                 // [28:21] overlap_bits, [31:29] zero
  output logic [1:0]  m_tuser,   // [0] out_of_range, [1] sprite_done
  output logic        m_tlast,   // last_of_run
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ssb_pkg::*;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_BYTE = 2'b01,
    ST_TAIL = 2'b10
  } seq_state_t;

  // Configuration registers.
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [5:0] width_bytes;
  logic [7:0] height_rows;
  blit_op_t   operation;

  // Sprite walk state.
  seq_state_t state;
  logic [5:0] column_count;
  logic [7:0] row_count;
  logic [7:0] carry_bits;
  logic       tail_done;

  logic        cfg_fire;
  logic        in_fire;
  logic        issue_tail;
  logic        room;
  logic [15:0] shifted;
  logic [7:0]  screen_row;
  logic [SUM_W-1:0] addr_sum;
  logic [6:0]  width_eff;
  logic [8:0]  height_eff;
  logic        row_end;
  logic        sprite_end;

  logic        op_valid;
  wr_op_t      op;
  rmw_status_t status;
  logic        res_valid;
  wr_result_t  res;

  // Result queue.
  wr_result_t        fifo [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fifo_cnt;
  logic              pop;
  wr_result_t        head;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Issue only when the queue can still hold this write and the one in flight.
  assign room       = ((CNT_W + 1)'(fifo_cnt) + (CNT_W + 1)'(status.stage_busy))
                      < (CNT_W + 1)'(FIFO_DEPTH);
  assign s_tready   = (state == ST_BYTE) && room && !status.clear_busy;
  assign in_fire    = s_tvalid && s_tready;
  assign issue_tail = (state == ST_TAIL) && room;

  // High byte is the byte shifted into place, low byte the bits that spill right.
  assign shifted    = {s_tdata, 8'h00} >> pos_x[2:0];

  assign width_eff  = (width_bytes == 6'd0) ? 7'd1 : {1'b0, width_bytes};
  assign height_eff = (height_rows == 8'd0) ? 9'd1 : {1'b0, height_rows};
  assign row_end    = ({1'b0, column_count} + 7'd1) >= width_eff;
  assign sprite_end = row_end && (({1'b0, row_count} + 9'd1) >= height_eff);

  // Screen row wraps at 256; columns past the row run on linearly.
  assign screen_row = pos_y + row_count;
  assign addr_sum   = {1'b0, row_base(screen_row)} + SUM_W'(pos_x[7:3])
                      + SUM_W'(column_count);

  assign op_valid = in_fire || issue_tail;
  assign op.addr  = addr_sum;
  assign op.value = (state == ST_TAIL) ? carry_bits : (shifted[15:8] | carry_bits);
  assign op.oor   = (int'(screen_row) >= SCREEN_ROWS) || (int'(addr_sum) >= FRAME_BYTES);
  assign op.last  = (state == ST_TAIL) ? 1'b1 : !row_end;
  assign op.done  = (state == ST_TAIL) ? tail_done : 1'b0;
  assign op.mode  = operation;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x        <= 8'd0;
      pos_y        <= 8'd0;
      width_bytes  <= 6'd1;
      height_rows  <= 8'd1;
      operation    <= OP_DRAW;
      state        <= ST_BYTE;
      column_count <= 6'd0;
      row_count    <= 8'd0;
      carry_bits   <= 8'h00;
      tail_done    <= 1'b0;
    end else if (cfg_fire && (cfg_index <= REG_OPERATION)) begin
      unique case (cfg_index)
        REG_POS_X:     pos_x       <= cfg_data;
        REG_POS_Y:     pos_y       <= cfg_data;
        REG_WIDTH:     width_bytes <= cfg_data[5:0];
        REG_HEIGHT:    height_rows <= cfg_data;
        REG_OPERATION: operation   <= blit_op_t'(cfg_data[1:0]);
        default:       pos_x       <= pos_x;
      endcase
      state        <= ST_BYTE;
      column_count <= 6'd0;
      row_count    <= 8'd0;
      carry_bits   <= 8'h00;
    end else if (in_fire) begin
      carry_bits   <= shifted[7:0];
      column_count <= column_count + 6'd1;
      if (row_end) begin
        state     <= ST_TAIL;
        tail_done <= sprite_end;
      end
    end else if (issue_tail) begin
      column_count <= 6'd0;
      carry_bits   <= 8'h00;
      row_count    <= tail_done ? 8'd0 : row_count + 8'd1;
      state        <= ST_BYTE;
    end
  end

  ssb_rmw #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_rmw (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op        (op),
    .restart   (cfg_fire && (cfg_index <= REG_OPERATION)),
    .status    (status),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue: the credit check above keeps it from overflowing.
  assign pop  = m_tvalid && m_tready;
  assign head = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_valid) begin
      fifo[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + CNT_W'(res_valid) - CNT_W'(pop);
    end
  end

  assign m_tvalid = (fifo_cnt != '0);
  assign m_tdata  = {3'b000, head.overlap, head.value, head.addr};
  assign m_tuser  = {head.done, head.oor};
  assign m_tlast  = head.last;

  // The queue never fills past its depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // A result is only pushed when a slot is free.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fifo_cnt < CNT_W'(FIFO_DEPTH)))
    else $error("result pushed into full queue");

  // The byte that closes a row is followed by its tail write.
  a_row_end_tail: assert property (@(posedge clk) disable iff (rst)
    (in_fire && row_end && !cfg_fire) |=> (state == ST_TAIL))
    else $error("row end without tail write");

  // No input byte is taken while the tail write is pending.
  a_tail_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAIL) |-> !s_tready)
    else $error("input accepted during tail write");

  // A sprite-done beat always closes its run.
  a_done_is_tlast: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("sprite done without tlast");

endmodule
